@@ hdl/pmv_pkg.sv @@
// Shared types, field positions and codes for the periodic health monitor voter.
package pmv_pkg;

  // Channel and register widths.
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 25;

  // Field widths.
  localparam int COUNT_W  = 3;
  localparam int PERIOD_W = 8;
  localparam int TOL_W    = 8;
  localparam int FID_W    = 8;
  localparam int FAILS_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int TRANS_W  = 32;
  localparam int GC_W     = 3;
  localparam int LANES    = 4;

  // Setup register layout.
  localparam int SETUP_PERIOD_LSB = 0;
  localparam int SETUP_TOL_LSB    = 8;
  localparam int SETUP_GATE_BIT   = 16;
  localparam int SETUP_FID_LSB    = 17;
  localparam logic [CFG_DATA_W-1:0] SETUP_RESET = 25'd1;

  localparam logic [FAILS_W-1:0] FAILS_MAX = 16'hFFFF;

  // Input tdata layout.
  localparam int IN_CHK_LSB   = 0;
  localparam int IN_VALUE_LSB = 4;

  // Output tdata layout.
  localparam int OUT_FID_LSB   = 0;
  localparam int OUT_FVAL_LSB  = 8;
  localparam int OUT_HF_BIT    = 40;
  localparam int OUT_GC_LSB    = 41;
  localparam int OUT_TRANS_LSB = 44;
  localparam int OUT_AP_BIT    = 76;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MONITOR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_LAST    = 3'd4;

  // Operation and result kind codes.
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_VOTE     = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FAULT  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic step;
    logic vote;
    logic emit_status;
  } pmv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic act_zero;
    logic step_last;
    logic step_blocked;
    logic out_free;
  } pmv_stat_t;

endpackage

@@ hdl/pmv_controller.sv @@
// Sequencer walking one input transaction through scan or vote, then status emission.
module pmv_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  input  pmv_pkg::pmv_stat_t stat,
  output pmv_pkg::pmv_cmd_t  cmd
);
  import pmv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_VOTE,
    S_STATUS
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  assign in_tready = in_tready_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    in_tready_nxt = in_tready_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.capture   = 1'b1;
          in_tready_nxt = 1'b0;
          state_nxt     = (in_tuser == OP_VOTE) ? S_VOTE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.act_zero) begin
          state_nxt = S_STATUS;
        end else if (!stat.step_blocked) begin
          cmd.step = 1'b1;
          if (stat.step_last) begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_VOTE: begin
        cmd.vote  = 1'b1;
        state_nxt = S_STATUS;
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          in_tready_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        in_tready_nxt = 1'b1;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

endmodule

@@ hdl/pmv_datapath.sv @@
// Monitor state, configuration registers, verdict logic and the output register.
module pmv_datapath #(
  parameter int MONITORS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pmv_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           cfg_wr_en,
  input  logic [pmv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  pmv_pkg::pmv_cmd_t              cmd,
  output pmv_pkg::pmv_stat_t             stat,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pmv_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import pmv_pkg::*;

  localparam int IDX_W = (MONITORS > 1) ? $clog2(MONITORS) : 1;

  // Countdown start value after registration: (index mod period) + 1.
  function automatic logic [PERIOD_W-1:0] stagger(input logic [1:0] i,
                                                  input logic [PERIOD_W-1:0] p);
    logic [1:0] m;
    begin
      if (p <= 8'd1) begin
        m = 2'd0;
      end else if (p == 8'd2) begin
        m = {1'b0, i[0]};
      end else if (p == 8'd3) begin
        m = (i == 2'd3) ? 2'd0 : i;
      end else begin
        m = i;
      end
      return {6'd0, m} + 8'd1;
    end
  endfunction

  // Per-monitor state.
  logic [CFG_DATA_W-1:0] setup_r [MONITORS];
  logic [CFG_DATA_W-1:0] setup_nxt [MONITORS];
  logic [PERIOD_W-1:0]   cd_r [MONITORS];
  logic [PERIOD_W-1:0]   cd_nxt [MONITORS];
  logic [FAILS_W-1:0]    cf_r [MONITORS];
  logic [FAILS_W-1:0]    cf_nxt [MONITORS];
  logic [MONITORS-1:0]   lp_r, lp_nxt;

  // Global state.
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               verdict_r, verdict_nxt;
  logic [TRANS_W-1:0] changes_r, changes_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // Captured input transaction.
  logic [LANES-1:0]   chk_r;
  logic [VALUE_W-1:0] value_r [LANES];

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_load;
  logic                   out_free;

  // Derived values.
  logic [COUNT_W-1:0]  act;
  logic [MONITORS-1:0] act_mask;
  logic [MONITORS-1:0] fail_vec;
  logic [VALUE_W-1:0]  val_vec [MONITORS];
  logic [MONITORS-1:0] contrib;
  logic [4:0]          gc_raw;
  logic [GC_W-1:0]     gc_sat;
  logic                all_pass;

  // Current monitor under scan.
  logic [CFG_DATA_W-1:0] cur_setup;
  logic [PERIOD_W-1:0]   cur_period;
  logic [FID_W-1:0]      cur_fid;
  logic                  cur_expire;
  logic                  cur_fail;
  logic                  step_fault;
  logic [1:0]            cfg_sel;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  // Active count clamps to the bank size.
  always_comb begin
    if ({2'b00, count_r} > 5'(MONITORS)) begin
      act = COUNT_W'(MONITORS);
    end else begin
      act = count_r;
    end
  end

  // Per-monitor views of the inputs and the gating test.
  always_comb begin
    gc_raw   = '0;
    all_pass = 1'b1;
    for (int i = 0; i < MONITORS; i++) begin
      act_mask[i] = (5'(i) < {2'b00, act});
      if (i < LANES) begin
        fail_vec[i] = chk_r[2'(i)];
        val_vec[i]  = value_r[2'(i)];
      end else begin
        fail_vec[i] = 1'b0;
        val_vec[i]  = '0;
      end
      contrib[i] = act_mask[i] && setup_r[i][SETUP_GATE_BIT] &&
                   (cf_r[i] > {8'd0, setup_r[i][SETUP_TOL_LSB +: TOL_W]});
      gc_raw = gc_raw + 5'(contrib[i]);
      if (act_mask[i] && !lp_r[i]) begin
        all_pass = 1'b0;
      end
    end
    gc_sat = (gc_raw > 5'd7) ? 3'd7 : gc_raw[GC_W-1:0];
  end

  // Scan step view of the selected monitor.
  always_comb begin
    cur_setup  = setup_r[idx_r];
    cur_period = (cur_setup[SETUP_PERIOD_LSB +: PERIOD_W] == '0) ? 8'd1 :
                 cur_setup[SETUP_PERIOD_LSB +: PERIOD_W];
    cur_fid    = cur_setup[SETUP_FID_LSB +: FID_W];
    cur_expire = (cd_r[idx_r] <= 8'd1);
    cur_fail   = fail_vec[idx_r];
    step_fault = cur_expire && cur_fail && (cur_fid != '0);
  end

  // Status toward the controller.
  always_comb begin
    stat.act_zero     = (act == '0);
    stat.step_last    = ((5'(idx_r) + 5'd1) == {2'b00, act});
    stat.step_blocked = step_fault && !out_free;
    stat.out_free     = out_free;
  end

  assign cfg_sel = 2'(cfg_index - REG_SETUP_FIRST);

  // Next state of the monitor bank, verdict and index.
  always_comb begin
    setup_nxt   = setup_r;
    cd_nxt      = cd_r;
    cf_nxt      = cf_r;
    lp_nxt      = lp_r;
    count_nxt   = count_r;
    verdict_nxt = verdict_r;
    changes_nxt = changes_r;
    idx_nxt     = idx_r;

    // Setup word writes re-register a monitor; a count write sets the monitor count.
    if (cfg_wr_en) begin
      unique case (cfg_index) inside
        REG_MONITOR_COUNT: begin
          count_nxt = cfg_wdata[COUNT_W-1:0];
        end
        [REG_SETUP_FIRST:REG_SETUP_LAST]: begin
          for (int i = 0; i < MONITORS; i++) begin
            if (i < LANES && 2'(i) == cfg_sel) begin
              setup_nxt[i] = cfg_wdata;
              cd_nxt[i]    = stagger(2'(i), cfg_wdata[SETUP_PERIOD_LSB +: PERIOD_W]);
              cf_nxt[i]    = '0;
              lp_nxt[i]    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.capture) begin
      idx_nxt = '0;
    end

    // One monitor per step.
    if (cmd.step) begin
      idx_nxt = idx_r + IDX_W'(1);
      for (int i = 0; i < MONITORS; i++) begin
        if (IDX_W'(i) == idx_r) begin
          if (!cur_expire) begin
            cd_nxt[i] = cd_r[i] - 8'd1;
          end else begin
            cd_nxt[i] = cur_period;
            if (!cur_fail) begin
              cf_nxt[i] = '0;
              lp_nxt[i] = 1'b1;
            end else begin
              if (cf_r[i] < FAILS_MAX) begin
                cf_nxt[i] = cf_r[i] + 16'd1;
              end
              lp_nxt[i] = 1'b0;
            end
          end
        end
      end
    end

    // Verdict update counts each change.
    if (cmd.vote) begin
      if ((gc_raw != '0) != verdict_r) begin
        verdict_nxt = (gc_raw != '0);
        changes_nxt = changes_r + 32'd1;
      end
    end
  end

  // Output register load: fault report during scan, status at the end.
  always_comb begin
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;
    if (cmd.step && step_fault) begin
      out_load     = 1'b1;
      out_data_nxt = '0;
      out_data_nxt[OUT_FID_LSB +: FID_W]    = cur_fid;
      out_data_nxt[OUT_FVAL_LSB +: VALUE_W] = val_vec[idx_r];
      out_user_nxt = KIND_FAULT;
      out_last_nxt = 1'b0;
    end else if (cmd.emit_status) begin
      out_load     = 1'b1;
      out_data_nxt = '0;
      out_data_nxt[OUT_HF_BIT]                = verdict_r;
      out_data_nxt[OUT_GC_LSB +: GC_W]        = gc_sat;
      out_data_nxt[OUT_TRANS_LSB +: TRANS_W]  = changes_r;
      out_data_nxt[OUT_AP_BIT]                = all_pass;
      out_user_nxt = KIND_STATUS;
      out_last_nxt = 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and monitor state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MONITORS; i++) begin
        setup_r[i] <= SETUP_RESET;
        cd_r[i]    <= 8'd1;
        cf_r[i]    <= '0;
      end
      lp_r        <= '1;
      count_r     <= '0;
      verdict_r   <= 1'b0;
      changes_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      setup_r     <= setup_nxt;
      cd_r        <= cd_nxt;
      cf_r        <= cf_nxt;
      lp_r        <= lp_nxt;
      count_r     <= count_nxt;
      verdict_r   <= verdict_nxt;
      changes_r   <= changes_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chk_r <= in_tdata[IN_CHK_LSB +: LANES];
      for (int k = 0; k < LANES; k++) begin
        value_r[k] <= in_tdata[IN_VALUE_LSB + k * VALUE_W +: VALUE_W];
      end
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ hdl/periodic_health_monitor_voter.sv @@
// Top level of the periodic health monitor voter: controller plus datapath.
//
// Input channel (in_*): one transaction per operation. in_tuser selects a
// check tick or a verdict consolidation; in_tdata carries the fail bits and
// the four measured values. Output channel (out_*): a tick yields one fault
// report per expiring, failing monitor with a nonzero fault id, in monitor
// order, then one status result marked by out_tlast; a consolidation yields the
// status result alone. Configuration (cfg_*) writes the monitor count and the
// four setup words; the user must write only while the block is idle; not enforced.
// Timing: a tick scans the active monitors in order and then loads the status
// result in the output register; one shared update path visits one monitor per
// cycle while no fault report waits on a stalled output. A consolidation passes
// through the vote state before the status result is loaded. in_tready rises on
// the edge that loads the status result.
// Reset (synchronous, active low) restores all setup words, countdowns,
// fail counts, verdict and transition count, and empties the output register.
// When the receiver stalls, the output register holds its result; the scan
// waits at a monitor that has a fault report to deliver, and the status
// result waits for the register to free.
module periodic_health_monitor_voter #(
  parameter int MONITORS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // bits from lsb: check_failed[3:0], value_0, value_1, value_2, value_3, zero pad
  input  logic [pmv_pkg::IN_TDATA_W-1:0]  in_tdata,
  // bit 0: operation
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // bits from lsb: fault_id, fault_value, health_failed, gating_count,
  // transitions, all_passing, zero pad
  output logic [pmv_pkg::OUT_TDATA_W-1:0] out_tdata,
  // bit 0: kind
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [pmv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pmv_pkg::*;

  pmv_cmd_t  cmd;
  pmv_stat_t stat;

  pmv_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmv_datapath #(
    .MONITORS (MONITORS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hdl/pmv_checker.sv @@
// Port-level assertions for the periodic health monitor voter and their binding.
module pmv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pmv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);
  import pmv_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Fault reports never close a transaction; a status result always does.
  a_fault_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == KIND_FAULT) != out_tlast))
    else $error("last flag does not match result kind");

  // Fault reports only come from monitors with a fault id.
  a_fault_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_FAULT) |-> (out_tdata[OUT_FID_LSB +: FID_W] != '0))
    else $error("fault report with zero fault id");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind periodic_health_monitor_voter pmv_checker u_pmv_checker (.*);
